### hw/rtl/alst_pkg.sv
// Package for the array list engine: field widths, command and status codes,
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block but alst_ram imports it.
package alst_pkg;

    localparam int ALST_DEPTH = 16;

    localparam int CMD_W = 3;
    localparam int POS_W = 4;
    localparam int VAL_W = 32;
    localparam int IDX_W = 4;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_REMOVE = 3'd4,
        CMD_FIND   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RA_POS,
        RA_PTR_M1,
        RA_PTR,
        RA_PTR_P1
    } t_rd_addr;

    typedef enum logic [1:0] {
        WA_FILL,
        WA_PTR,
        WA_POS
    } t_wr_addr;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_FILL,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        FILL_HOLD,
        FILL_INC,
        FILL_DEC,
        FILL_CLR
    } t_fill_op;

    typedef struct packed {
        logic       cap;
        logic       rd_en;
        t_rd_addr   rd_addr;
        logic       wr_en;
        t_wr_addr   wr_addr;
        logic       wr_from_ram;
        t_ptr_op    ptr_op;
        t_fill_op   fill_op;
        logic       set_st;
        t_status    st;
        logic       take_rd;
        logic       take_hit;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pos_gt_fill;
        logic             pos_ge_fill;
        logic             ptr_gt_pos;
        logic             ptr_lt_fill;
        logic             ptr_p1_lt_fill;
        logic             match;
        logic             out_free;
    } t_dp_stat;

endpackage

### hw/rtl/array_list_engine.sv
// Top level of the array list engine: a fixed-capacity ordered list of
// signed words. Instantiates the controller and the datapath; uses alst_pkg.
//
//   channel   direction  handshake               payload
//   in        sink       i_in_valid/o_in_stall   i_command i_position i_value
//   out       source     o_out_valid/i_out_stall o_read_value o_found
//                                                o_found_index o_status
//                                                o_item_count o_empty_res
//
// One command is handled at a time. The entry RAM has one read and one write
// port with a registered read, and each stored entry that a command walks
// is first read and then written or compared. Append, clear and the unused
// code walk no entries; get and set read one; insert moves each entry at or
// above the position up by one; find reads entries until the first match or
// the end of the list; remove searches the same way and then moves every
// later entry down by one. Reset is synchronous and active low; it empties
// the list, but entry contents stay undefined until written.
// A new command transfer is taken while an earlier result still waits in the
// output register; a result that finds the output register still stalled
// waits there until it drains.
module array_list_engine
    import alst_pkg::*;
#(
    parameter int DEPTH = ALST_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_found_index,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_item_count,
    output logic                    o_empty_res
);

    // Command and status groups between the state machine and the datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller stalls the input channel whenever it is not idle, and
    // steers the RAM ports, the pointer and the fill count every cycle.
    alst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the list itself, the captured command and the
    // output register that parts the result side from the command side.
    alst_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .o_item_count  (o_item_count),
        .o_empty_res   (o_empty_res)
    );

endmodule

### hw/rtl/alst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module alst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/alst_dp.sv
// Datapath of the array list engine: captured item, fill count, walk pointer,
// entry RAM, result fields and the output register.
// Depends on alst_pkg and alst_ram.
module alst_dp
    import alst_pkg::*;
#(
    parameter int DEPTH = ALST_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_found_index,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_item_count,
    output logic                    o_empty_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int OW   = (CW > CNT_W) ? CW : CNT_W;

    logic [CMD_W-1:0] r_cmd;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    r_ptr;
    logic [VAL_W-1:0] r_rd;
    logic             r_fnd;
    logic [IDX_W-1:0] r_fidx;
    t_status          r_st;
    logic             r_o_valid;
    logic [VAL_W-1:0] r_o_rd;
    logic             r_o_fnd;
    logic [IDX_W-1:0] r_o_fidx;
    logic [ST_W-1:0]  r_o_st;
    logic [CNT_W-1:0] r_o_cnt;
    logic             r_o_empty;

    logic [CMPW-1:0]  w_pos_ext;
    logic [CMPW-1:0]  w_fill_ext;
    logic [CMPW-1:0]  w_ptr_ext;
    logic [CW-1:0]    w_ptr_m1;
    logic [CW:0]      w_ptr_p1;
    logic [OW-1:0]    w_cnt_ext;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic [VAL_W-1:0] w_wr_data;
    logic [VAL_W-1:0] w_rd_data;

    assign w_pos_ext  = CMPW'(r_pos);
    assign w_fill_ext = CMPW'(r_fill);
    assign w_ptr_ext  = CMPW'(r_ptr);
    assign w_ptr_m1   = r_ptr - 1'b1;
    assign w_ptr_p1   = {1'b0, r_ptr} + 1'b1;
    assign w_cnt_ext  = OW'(r_fill);

    always_comb begin
        unique case (i_cmd.rd_addr)
            RA_POS:    w_rd_addr = w_pos_ext[AW-1:0];
            RA_PTR_M1: w_rd_addr = w_ptr_m1[AW-1:0];
            RA_PTR:    w_rd_addr = r_ptr[AW-1:0];
            RA_PTR_P1: w_rd_addr = w_ptr_p1[AW-1:0];
            default:   w_rd_addr = r_ptr[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_addr)
            WA_FILL: w_wr_addr = r_fill[AW-1:0];
            WA_PTR:  w_wr_addr = r_ptr[AW-1:0];
            WA_POS:  w_wr_addr = w_pos_ext[AW-1:0];
            default: w_wr_addr = r_ptr[AW-1:0];
        endcase
    end

    assign w_wr_data = i_cmd.wr_from_ram ? w_rd_data : r_val;

    alst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Captured item and per-item result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd  <= i_command;
            r_pos  <= i_position;
            r_val  <= i_value;
            r_rd   <= '0;
            r_fnd  <= 1'b0;
            r_fidx <= '0;
            r_st   <= ST_OK;
        end else begin
            if (i_cmd.set_st) begin
                r_st <= i_cmd.st;
            end
            if (i_cmd.take_rd) begin
                r_rd <= w_rd_data;
            end
            if (i_cmd.take_hit) begin
                r_fnd  <= 1'b1;
                r_fidx <= w_ptr_ext[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.ptr_op)
            PTR_HOLD: r_ptr <= r_ptr;
            PTR_ZERO: r_ptr <= '0;
            PTR_FILL: r_ptr <= r_fill;
            PTR_INC:  r_ptr <= w_ptr_p1[CW-1:0];
            PTR_DEC:  r_ptr <= w_ptr_m1;
            default:  r_ptr <= r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            unique case (i_cmd.fill_op)
                FILL_HOLD: r_fill <= r_fill;
                FILL_INC:  r_fill <= r_fill + 1'b1;
                FILL_DEC:  r_fill <= r_fill - 1'b1;
                FILL_CLR:  r_fill <= '0;
                default:   r_fill <= r_fill;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_rd    <= r_rd;
            r_o_fnd   <= r_fnd;
            r_o_fidx  <= r_fidx;
            r_o_st    <= r_st;
            r_o_cnt   <= w_cnt_ext[CNT_W-1:0];
            r_o_empty <= (r_fill == '0);
        end
    end

    assign o_stat.cmd            = r_cmd;
    assign o_stat.full           = (r_fill == CW'(DEPTH));
    assign o_stat.pos_gt_fill    = (w_pos_ext > w_fill_ext);
    assign o_stat.pos_ge_fill    = (w_pos_ext >= w_fill_ext);
    assign o_stat.ptr_gt_pos     = (w_ptr_ext > w_pos_ext);
    assign o_stat.ptr_lt_fill    = (r_ptr < r_fill);
    assign o_stat.ptr_p1_lt_fill = (w_ptr_p1 < {1'b0, r_fill});
    assign o_stat.match          = (w_rd_data == r_val);
    assign o_stat.out_free       = !r_o_valid || !i_out_stall;

    assign o_out_valid   = r_o_valid;
    assign o_read_value  = r_o_rd;
    assign o_found       = r_o_fnd;
    assign o_found_index = r_o_fidx;
    assign o_status      = r_o_st;
    assign o_item_count  = r_o_cnt;
    assign o_empty_res   = r_o_empty;

endmodule

### hw/rtl/alst_ctrl.sv
// Controller of the array list engine: one-hot state machine that sequences
// the datapath through decode, shift and search walks.
// Depends on alst_pkg.
module alst_ctrl
    import alst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_INS_RD   = 10'b0000000100,
        S_INS_WR   = 10'b0000001000,
        S_RD_WAIT  = 10'b0000010000,
        S_SRCH_RD  = 10'b0000100000,
        S_SRCH_CMP = 10'b0001000000,
        S_SHF_RD   = 10'b0010000000,
        S_SHF_WR   = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_stat.cmd)
                    CMD_APPEND: begin
                        if (i_stat.full) begin
                            w_cmd.set_st = 1'b1;
                            w_cmd.st     = ST_FULL;
                        end else begin
                            w_cmd.wr_en   = 1'b1;
                            w_cmd.wr_addr = WA_FILL;
                            w_cmd.fill_op = FILL_INC;
                        end
                    end
                    CMD_INSERT: begin
                        if (i_stat.pos_gt_fill) begin
                            w_cmd.set_st = 1'b1;
                            w_cmd.st     = ST_RANGE;
                        end else if (i_stat.full) begin
                            w_cmd.set_st = 1'b1;
                            w_cmd.st     = ST_FULL;
                        end else begin
                            w_cmd.ptr_op = PTR_FILL;
                            n_state      = S_INS_RD;
                        end
                    end
                    CMD_GET, CMD_SET: begin
                        if (i_stat.pos_ge_fill) begin
                            w_cmd.set_st = 1'b1;
                            w_cmd.st     = ST_RANGE;
                        end else begin
                            w_cmd.rd_en   = 1'b1;
                            w_cmd.rd_addr = RA_POS;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    CMD_REMOVE, CMD_FIND: begin
                        w_cmd.ptr_op = PTR_ZERO;
                        n_state      = S_SRCH_RD;
                    end
                    CMD_CLEAR: begin
                        w_cmd.fill_op = FILL_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_RD: begin
                if (i_stat.ptr_gt_pos) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = RA_PTR_M1;
                    n_state       = S_INS_WR;
                end else begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_addr = WA_POS;
                    w_cmd.fill_op = FILL_INC;
                    n_state       = S_DONE;
                end
            end
            S_INS_WR: begin
                w_cmd.wr_en       = 1'b1;
                w_cmd.wr_addr     = WA_PTR;
                w_cmd.wr_from_ram = 1'b1;
                w_cmd.ptr_op      = PTR_DEC;
                n_state           = S_INS_RD;
            end
            S_RD_WAIT: begin
                w_cmd.take_rd = 1'b1;
                if (i_stat.cmd == CMD_SET) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_addr = WA_POS;
                end
                n_state = S_DONE;
            end
            S_SRCH_RD: begin
                if (i_stat.ptr_lt_fill) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = RA_PTR;
                    n_state       = S_SRCH_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    w_cmd.take_hit = 1'b1;
                    n_state = (i_stat.cmd == CMD_REMOVE) ? S_SHF_RD : S_DONE;
                end else begin
                    w_cmd.ptr_op = PTR_INC;
                    n_state      = S_SRCH_RD;
                end
            end
            S_SHF_RD: begin
                if (i_stat.ptr_p1_lt_fill) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = RA_PTR_P1;
                    n_state       = S_SHF_WR;
                end else begin
                    w_cmd.fill_op = FILL_DEC;
                    n_state       = S_DONE;
                end
            end
            S_SHF_WR: begin
                w_cmd.wr_en       = 1'b1;
                w_cmd.wr_addr     = WA_PTR;
                w_cmd.wr_from_ram = 1'b1;
                w_cmd.ptr_op      = PTR_INC;
                n_state           = S_SHF_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

### test/array_list_engine_checker.sv
// Checker for the array list engine: watches both channels, keeps a shadow
// copy of the list, predicts every result and compares it field by field.
// Depends on alst_pkg for widths and command and status codes.
module array_list_engine_checker
    import alst_pkg::*;
#(
    parameter int DEPTH = ALST_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [VAL_W-1:0] i_read_value,
    input  logic                    i_found,
    input  logic [IDX_W-1:0]        i_found_index,
    input  logic [ST_W-1:0]         i_status,
    input  logic [CNT_W-1:0]        i_item_count,
    input  logic                    i_empty_res,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_list_fill
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic [IDX_W-1:0]        found_index;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        item_count;
        logic                    empty_res;
    } t_list_result;

    logic signed [VAL_W-1:0] shadow_words [DEPTH];
    int                      shadow_fill;
    t_list_result            awaited_results [$];

    // Applies one command to the shadow list and returns the result it gives.
    function automatic t_list_result apply_list_command(
        input logic [CMD_W-1:0]        cmd,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val
    );
        t_list_result r;
        int           p;
        int           hit;
        int           k;
        r   = '0;
        p   = int'(pos);
        hit = shadow_fill;
        for (k = shadow_fill - 1; k >= 0; k--) begin
            if (shadow_words[k] == val) hit = k;
        end
        case (cmd)
            CMD_APPEND: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            CMD_INSERT: begin
                // The position check wins over the full check.
                if (p > shadow_fill) begin
                    r.status = ST_RANGE;
                end else if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = shadow_fill; k > p; k--) shadow_words[k] = shadow_words[k-1];
                    shadow_words[p] = val;
                    shadow_fill++;
                end
            end
            CMD_GET: begin
                if (p >= shadow_fill) r.status = ST_RANGE;
                else r.read_value = shadow_words[p];
            end
            CMD_SET: begin
                if (p >= shadow_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value    = shadow_words[p];
                    shadow_words[p] = val;
                end
            end
            CMD_REMOVE: begin
                if (hit < shadow_fill) begin
                    r.found       = 1'b1;
                    r.found_index = IDX_W'(hit);
                    for (k = hit; k + 1 < shadow_fill; k++) shadow_words[k] = shadow_words[k+1];
                    shadow_fill--;
                end
            end
            CMD_FIND: begin
                if (hit < shadow_fill) begin
                    r.found       = 1'b1;
                    r.found_index = IDX_W'(hit);
                end
            end
            CMD_CLEAR: shadow_fill = 0;
            default: ;
        endcase
        r.item_count = CNT_W'(shadow_fill);
        r.empty_res  = (shadow_fill == 0);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result due;
        if (!i_rst_n) begin
            awaited_results.delete();
            shadow_fill  = 0;
            o_fail_count = 0;
        end else begin
            // A result leaving at this edge always belongs to an earlier command.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no result awaited");
                    o_fail_count++;
                end else begin
                    due = awaited_results.pop_front();
                    report_field("read_value", due.read_value, i_read_value);
                    report_field("found", 32'(due.found), 32'(i_found));
                    report_field("found_index", 32'(due.found_index), 32'(i_found_index));
                    report_field("status", 32'(due.status), 32'(i_status));
                    report_field("item_count", 32'(due.item_count), 32'(i_item_count));
                    report_field("empty_res", 32'(due.empty_res), 32'(i_empty_res));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_list_command(i_command, i_position, i_value));
            end
        end
        o_pending   = awaited_results.size();
        o_list_fill = shadow_fill;
    end

endmodule

### test/array_list_engine_tb.sv
// Top of the array list engine testbench: clock, reset, command stimulus,
// output stalls, a watchdog and the verdict. Uses alst_pkg, the engine and
// array_list_engine_checker, which does all prediction and comparison.
module array_list_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import alst_pkg::*;

    localparam int DEPTH          = ALST_DEPTH;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int IDLE_PERCENT   = 37;
    // The tail wait covers the longest command.
    localparam int TAIL_CYCLES    = 4 * DEPTH + 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // The engine treats code 7 as a no-op that still reports the count.
    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        command     = '0;
    logic [POS_W-1:0]        position    = '0;
    logic signed [VAL_W-1:0] value       = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [IDX_W-1:0]        found_index;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        item_count;
    logic                    empty_res;

    int fail_count;
    int pending;
    int list_fill;
    int quiet_cycles = 0;

    // While calm is set, neither side inserts idle cycles.
    bit calm = 1'b0;

    logic signed [VAL_W-1:0] value_pool [8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    array_list_engine #(.DEPTH(DEPTH)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_position    (position),
        .i_value       (value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_value  (read_value),
        .o_found       (found),
        .o_found_index (found_index),
        .o_status      (status),
        .o_item_count  (item_count),
        .o_empty_res   (empty_res)
    );

    array_list_engine_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_position    (position),
        .i_value       (value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_read_value  (read_value),
        .i_found       (found),
        .i_found_index (found_index),
        .i_status      (status),
        .i_item_count  (item_count),
        .i_empty_res   (empty_res),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_list_fill   (list_fill)
    );

    // The result side stalls at random on every falling edge, except while
    // calm, so stalls land on every phase of a command's walk.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // The watchdog ends the run when no transfer happens on either channel
    // for far longer than the slowest command plus the longest stall.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Moves to the next falling edge and adds a random run of idle cycles
    // on the command side. Valid is only lowered here, never raised.
    task automatic idle_gap();
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    // Presents one command and holds it until the engine takes the transfer.
    // The stall is read right after the edge, so it is the value the engine
    // saw at that edge.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
        in_valid = 1'b1;
        command  = cmd;
        position = pos;
        value    = val;
        do @(posedge clk); while (in_stall);
    endtask

    // Holds the command side off until every awaited result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Command mix: a growing list favors append and insert, a shrinking one
    // favors remove. A small share is uniform noise, the unused code too.
    function automatic logic [CMD_W-1:0] pick_command(input bit shrinking);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return CMD_W'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (!shrinking) begin
            if (roll < 30) return CMD_APPEND;
            if (roll < 55) return CMD_INSERT;
            if (roll < 66) return CMD_GET;
            if (roll < 77) return CMD_SET;
            if (roll < 87) return CMD_REMOVE;
            if (roll < 97) return CMD_FIND;
            if (roll < 98) return CMD_CLEAR;
            return CMD_NOP;
        end
        if (roll < 8)  return CMD_APPEND;
        if (roll < 16) return CMD_INSERT;
        if (roll < 28) return CMD_GET;
        if (roll < 40) return CMD_SET;
        if (roll < 78) return CMD_REMOVE;
        if (roll < 94) return CMD_FIND;
        if (roll < 97) return CMD_CLEAR;
        return CMD_NOP;
    endfunction

    // Positions mostly fall inside the list so that inserts, gets and sets
    // do real work; the rest are uniform and often out of range.
    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        int top;
        if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 15));
        top = (cmd == CMD_INSERT) ? list_fill : list_fill - 1;
        if (top < 0) top = 0;
        if (top > 15) top = 15;
        return POS_W'($urandom_range(0, top));
    endfunction

    // Values mostly come from a small pool so that finds and removes hit,
    // and repeated values test that the first match is the one taken.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, 7)];
        return VAL_W'($urandom);
    endfunction

    initial begin
        int                      k;
        int                      n;
        bit                      shrinking;
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] last_word;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = -32'sd1;
        value_pool[3] = 32'sd0;
        for (k = 4; k < 8; k++) value_pool[k] = VAL_W'($urandom);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An empty list rejects a get and an insert past the
        // count, then the extremes of the value and -1 go in, -1 is found and the largest value is read back.
        idle_gap(); send_command(CMD_GET, 4'd0, 32'sd0);
        idle_gap(); send_command(CMD_INSERT, 4'd15, 32'sd7);
        idle_gap(); send_command(CMD_INSERT, 4'd0, 32'sh8000_0000);
        idle_gap(); send_command(CMD_APPEND, 4'd0, 32'sh7fff_ffff);
        idle_gap(); send_command(CMD_APPEND, 4'd9, -32'sd1);
        idle_gap(); send_command(CMD_FIND, 4'd0, -32'sd1);
        idle_gap(); send_command(CMD_SET, 4'd1, 32'sd0);
        // A set at the count is out of range; a find with no match reports 0.
        idle_gap(); send_command(CMD_SET, 4'd3, 32'sd5);
        idle_gap(); send_command(CMD_REMOVE, 4'd0, 32'sd0);
        idle_gap(); send_command(CMD_FIND, 4'd0, 32'sd12345);
        idle_gap(); send_command(CMD_NOP, 4'd15, 32'shffff_ffff);

        // Fill the list to capacity by inserting at the count each time.
        last_word = '0;
        for (k = 2; k < DEPTH; k++) begin
            last_word = VAL_W'($urandom);
            idle_gap(); send_command(CMD_INSERT, POS_W'(k), last_word);
        end

        // A full list rejects append and a valid insert; the last slot is
        // read and its word removed, then the list is emptied.
        idle_gap(); send_command(CMD_APPEND, 4'd0, 32'sd1);
        idle_gap(); send_command(CMD_INSERT, 4'd3, 32'sd1);
        idle_gap(); send_command(CMD_GET, 4'd15, 32'sd0);
        idle_gap(); send_command(CMD_REMOVE, 4'd0, last_word);
        idle_gap(); send_command(CMD_CLEAR, 4'd0, 32'sd0);

        // Let every directed result drain before the random part.
        drain_results();

        // Random part. The list swings between growing and shrinking phases
        // so that it keeps passing through empty and full.
        shrinking = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 900 && n < 1150);
            if (n == 500 || $urandom_range(0, 199) == 0) drain_results();
            idle_gap();
            if (list_fill >= DEPTH - 1 && $urandom_range(0, 3) == 0) shrinking = 1'b1;
            if (list_fill <= 1) shrinking = 1'b0;
            if ($urandom_range(0, 49) == 0) shrinking = !shrinking;
            cmd = pick_command(shrinking);
            pos = pick_position(cmd);
            val = pick_value();
            send_command(cmd, pos, val);
        end
        calm = 1'b0;

        // Wait for the last results, then a while longer so that a stray
        // extra result would still be caught by the checker.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
